FILE: rtl/inversion_ratio_strategy_select_macros.svh
// ---------------------------------------------------------------------------
// inversion_ratio_strategy_select macros
// assertion shorthands used by irss_core
// ---------------------------------------------------------------------------
`ifndef INVERSION_RATIO_STRATEGY_SELECT_MACROS_SVH
`define INVERSION_RATIO_STRATEGY_SELECT_MACROS_SVH

// same-cycle implication, disabled during reset
`define IRSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irss assertion failed");

// next-cycle implication, disabled during reset
`define IRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irss assertion failed");

`endif

FILE: rtl/irss_pkg.sv
// ---------------------------------------------------------------------------
// irss_pkg
// types and constants of the inversion ratio strategy select block
// ---------------------------------------------------------------------------
package irss_pkg;

    // default sequence capacity
    localparam int unsigned MAX_ITEMS_DEF = 64;

    // widths of the transfer fields
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OUT_W   = 11;
    localparam int unsigned STRAT_W = 2;

    // largest count an output field can show
    localparam logic [OUT_W-1:0] FIELD_MAX = '1;

    // strategy codes
    localparam logic [STRAT_W-1:0] STRAT_SELECTION = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_CHUNK     = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_RADIX     = 2'd2;
    localparam logic [STRAT_W-1:0] FORCED_ADAPTIVE = 2'd3;

    // input transfer
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } irss_in_t;

    // result transfer
    typedef struct packed {
        logic [OUT_W-1:0]   inversions;
        logic [OUT_W-1:0]   pair_count;
        logic [STRAT_W-1:0] strategy;
        logic               overflow;
    } irss_out_t;

    // scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } irss_state_t;

endpackage

FILE: rtl/irss_ram.sv
// ---------------------------------------------------------------------------
// irss_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module irss_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/irss_core.sv
// ---------------------------------------------------------------------------
// irss_core
// stores the sequence and counts inversions with one shared comparator
// ---------------------------------------------------------------------------
`include "inversion_ratio_strategy_select_macros.svh"

module irss_core #(
    parameter int unsigned MAX_ITEMS = irss_pkg::MAX_ITEMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  irss_pkg::irss_in_t              in_data,
    input  logic [irss_pkg::STRAT_W-1:0]    forced,
    output logic                            res_valid,
    input  logic                            res_ready,
    output irss_pkg::irss_out_t             res_data
);

    import irss_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned TW = $clog2((MAX_ITEMS * (MAX_ITEMS - 1)) / 2 + 1);
    localparam int unsigned SW = (TW > OUT_W) ? TW : OUT_W;

    irss_state_t state_reg, state_next;

    logic [CW-1:0]              count_reg;
    logic [AW-1:0]              idx_reg;
    logic [AW-1:0]              scan_last_reg;
    logic                       last_reg;
    logic                       rd_vld_reg, rd_vld_next;
    logic [TW-1:0]              inv_reg;
    logic [TW-1:0]              pair_reg;
    logic                       ovf_reg;
    logic signed [VALUE_W-1:0]  key_reg;

    logic                       in_fire;
    logic                       res_fire;
    logic                       has_room;
    logic                       scan_end;
    logic                       greater;
    logic [AW-1:0]              rd_addr;
    logic [VALUE_W-1:0]         rd_data;
    logic [SW-1:0]              inv_ext;
    logic [SW-1:0]              pair_ext;
    logic [TW+2:0]              inv_x2;
    logic [TW+2:0]              inv_x5;
    logic [TW+2:0]              pair_wide;
    logic [STRAT_W-1:0]         strat;

    assign in_fire  = in_valid && in_ready;
    assign res_fire = res_valid && res_ready;
    assign has_room = count_reg < CW'(MAX_ITEMS);
    assign scan_end = idx_reg == scan_last_reg;
    assign greater  = $signed(rd_data) > key_reg;

    // sequence store
    irss_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_fire && has_room),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_data.value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_room && (count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!last_reg || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        rd_vld_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready    = 1'b1;
            ST_SCAN:   rd_vld_next = 1'b1;
            ST_DRAIN:  rd_vld_next = 1'b0;
            ST_FINISH: res_valid   = last_reg;
            default:   in_ready    = 1'b0;
        endcase
    end

    assign rd_addr = idx_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // sequence counters and scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            scan_last_reg <= '0;
            last_reg      <= 1'b0;
            inv_reg       <= '0;
            pair_reg      <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                last_reg <= in_data.last_item;
                idx_reg  <= '0;
                if (has_room)
                begin
                    scan_last_reg <= AW'(count_reg - CW'(1));
                    count_reg     <= count_reg + CW'(1);
                    pair_reg      <= pair_reg + TW'(count_reg);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_SCAN) && !scan_end)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            // one compare result per cycle from the store
            if (rd_vld_reg && greater)
            begin
                inv_reg <= inv_reg + TW'(1);
            end
            // sequence done, start over
            if (res_fire)
            begin
                count_reg <= '0;
                inv_reg   <= '0;
                pair_reg  <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // incoming value held for the scan
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg <= in_data.value;
        end
    end

    // ratio tests 2m >= t and 5m >= t
    assign inv_x2    = (TW + 3)'(inv_reg) << 1;
    assign inv_x5    = ((TW + 3)'(inv_reg) << 2) + (TW + 3)'(inv_reg);
    assign pair_wide = (TW + 3)'(pair_reg);

    always_comb
    begin
        priority if (forced != FORCED_ADAPTIVE)
        begin
            strat = forced;
        end
        else if (pair_reg == '0)
        begin
            strat = STRAT_SELECTION;
        end
        else if (inv_x2 >= pair_wide)
        begin
            strat = STRAT_RADIX;
        end
        else if (inv_x5 >= pair_wide)
        begin
            strat = STRAT_CHUNK;
        end
        else
        begin
            strat = STRAT_SELECTION;
        end
    end

    // saturate counts into the result fields
    assign inv_ext  = SW'(inv_reg);
    assign pair_ext = SW'(pair_reg);

    always_comb
    begin
        res_data.inversions = (inv_ext > SW'(FIELD_MAX)) ? FIELD_MAX : inv_ext[OUT_W-1:0];
        res_data.pair_count = (pair_ext > SW'(FIELD_MAX)) ? FIELD_MAX : pair_ext[OUT_W-1:0];
        res_data.strategy   = strat;
        res_data.overflow   = ovf_reg;
    end

    // checks
    `IRSS_ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ITEMS))
    `IRSS_ASSERT_IMPL(a_rd_window, clk, rst_n, rd_vld_reg,
        (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
    `IRSS_ASSERT_IMPL(a_inv_le_pair, clk, rst_n, state_reg == ST_IDLE, inv_reg <= pair_reg)
    `IRSS_ASSERT_NEXT(a_clear_after_res, clk, rst_n, res_fire,
        (count_reg == '0) && (inv_reg == '0) && (pair_reg == '0) && !ovf_reg)

endmodule

FILE: rtl/inversion_ratio_strategy_select.sv
// ---------------------------------------------------------------------------
// inversion_ratio_strategy_select
// disorder ratio of a value sequence and choice of sort strategy
// ---------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one signed value per
//   transfer, with last_item set on the final value of a sequence.
//   out channel (out_valid/out_ready/out_data) carries one result per
//   sequence: inversion count, pair count, strategy code, overflow flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the forced strategy;
//   code 3 selects the adaptive choice from the inversion ratio.
// Sequencing:
//   an item arriving with k values already stored passes through accept,
//   k store reads, a compare drain and finish; an item with nothing stored
//   or beyond capacity passes through accept and finish. The single store
//   read port and one comparator set this; no new item is taken before
//   finish. The output register takes the result as finish hands it over.
// Reset: forced strategy returns to adaptive, sequence state clears.
// Stall: a pending result sits in the output register while the next item
//   is taken; a second finished result waits in the core until it drains.
// ---------------------------------------------------------------------------
module inversion_ratio_strategy_select #(
    parameter int unsigned MAX_ITEMS = irss_pkg::MAX_ITEMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  irss_pkg::irss_in_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output irss_pkg::irss_out_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irss_pkg::STRAT_W-1:0]    cfg_data
);

    import irss_pkg::*;

    logic [STRAT_W-1:0] forced_reg;
    logic               out_valid_reg;
    irss_out_t          out_data_reg;
    logic               res_valid;
    logic               res_ready;
    irss_out_t          res_data;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forced_reg <= FORCED_ADAPTIVE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            forced_reg <= cfg_data;
        end
    end

    // scan core
    irss_core #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .forced    (forced_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
